// File: design/mpsd_pkg.sv
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared types and operation codes for the message pool shift deque.
// ----------------------------------------------------------------------------
package mpsd_pkg;

  localparam int unsigned MSG_W   = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_FLUSH     = 2'd0,
    OP_PUSH_TAIL = 2'd1,
    OP_PUSH_HEAD = 2'd2,
    OP_POP_TAIL  = 2'd3
  } op_t;

  // Per-transfer command broadcast to every cell. All zero means hold.
  typedef struct packed {
    logic flush;
    logic push_tail;
    logic push_head;
    logic full;
  } cell_ctl_t;

endpackage

// File: design/mpsd_cell.sv
// ----------------------------------------------------------------------------
// mpsd_cell
// One slot of the shift row. Holds one byte and, on a command, loads the new
// byte, takes a neighbor's byte, clears or holds.
// ----------------------------------------------------------------------------
module mpsd_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX   = 0,
  parameter int unsigned FW    = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mpsd_pkg::cell_ctl_t       ctl,
  input  logic [FW-1:0]             fill,
  input  logic [mpsd_pkg::MSG_W-1:0] msg,
  input  logic [mpsd_pkg::MSG_W-1:0] left_data,
  input  logic [mpsd_pkg::MSG_W-1:0] right_data,
  output logic [mpsd_pkg::MSG_W-1:0] data_o,
  output logic [mpsd_pkg::MSG_W-1:0] tap_o
);
  import mpsd_pkg::*;

  localparam logic [FW-1:0] MY_IDX  = FW'(IDX);
  localparam logic [FW-1:0] MY_NEXT = FW'(IDX + 1);
  localparam bit            IS_HEAD = (IDX == 0);
  localparam bit            IS_LAST = (IDX == DEPTH - 1);

  logic [MSG_W-1:0] data_r;
  logic [MSG_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.flush) begin
      data_nxt = '0;
    end else if (ctl.push_tail) begin
      if (ctl.full) begin
        // full: whole row moves toward the head, new byte lands in the last slot
        data_nxt = IS_LAST ? msg : right_data;
      end else if (fill == MY_IDX) begin
        data_nxt = msg;
      end
    end else if (ctl.push_head) begin
      if (IS_HEAD) begin
        data_nxt = msg;
      end else if (ctl.full || MY_IDX <= fill) begin
        data_nxt = left_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_o = data_r;
  // only the current tail slot drives the pop bus
  assign tap_o  = (fill == MY_NEXT) ? data_r : '0;

endmodule

// File: design/message_pool_shift_deque.sv
// ----------------------------------------------------------------------------
// message_pool_shift_deque
// Bounded byte deque built from a row of shift cells plus a fill count.
// ----------------------------------------------------------------------------
// One operation (flush, push at tail, push at head, pop from tail) is taken
// per clock and every transfer in produces exactly one result, registered and
// shown from the output register. All cells of the row shift or load in
// parallel, so the rate is one item per cycle; the input stalls only while
// a finished result sits in the output register and the output side stalls.
// Pushes on a full pool drop the oldest (tail push) or the last (head push)
// entry and flag it. Pop on an empty pool returns the configured empty code.
// count reports the fill level modulo 32.
// ----------------------------------------------------------------------------
module message_pool_shift_deque #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mpsd_pkg::OP_W-1:0]     in_op,
  input  logic [mpsd_pkg::MSG_W-1:0]    in_msg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mpsd_pkg::MSG_W-1:0]    out_value,
  output logic                          out_valid_res,
  output logic [mpsd_pkg::COUNT_W-1:0]  out_count,
  output logic                          out_dropped,
  input  logic                          cfg_we,
  input  logic [mpsd_pkg::MSG_W-1:0]    cfg_wdata
);
  import mpsd_pkg::*;

  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] FULL_LVL = FW'(DEPTH);

  logic [MSG_W-1:0] empty_code_r;
  logic [FW-1:0]    fill_r;
  logic [FW-1:0]    fill_nxt;

  logic             out_valid_r;
  logic [MSG_W-1:0] out_value_r;
  logic             out_valid_res_r;
  logic [COUNT_W-1:0] out_count_r;
  logic             out_dropped_r;

  logic             fire;
  logic             full;
  logic             is_push;
  logic             pop_hit;
  op_t              op;
  cell_ctl_t        ctl;
  logic [MSG_W-1:0] tap_or;

  logic [MSG_W-1:0] cell_data [DEPTH];
  logic [MSG_W-1:0] cell_tap  [DEPTH];
  logic [MSG_W-1:0] left_w    [DEPTH];
  logic [MSG_W-1:0] right_w   [DEPTH];

  assign in_stall = out_valid_r & out_stall;
  assign fire     = in_valid & ~in_stall;
  assign op       = op_t'(in_op);
  assign full     = (fill_r == FULL_LVL);
  assign is_push  = (op == OP_PUSH_TAIL) || (op == OP_PUSH_HEAD);
  assign pop_hit  = (op == OP_POP_TAIL) && (fill_r != '0);

  always_comb begin
    ctl           = '0;
    ctl.full      = full;
    ctl.flush     = fire && (op == OP_FLUSH);
    ctl.push_tail = fire && (op == OP_PUSH_TAIL);
    ctl.push_head = fire && (op == OP_PUSH_HEAD);
  end

  always_comb begin
    case (op)
      OP_FLUSH:     fill_nxt = '0;
      OP_PUSH_TAIL,
      OP_PUSH_HEAD: fill_nxt = full ? fill_r : fill_r + FW'(1);
      OP_POP_TAIL:  fill_nxt = pop_hit ? fill_r - FW'(1) : fill_r;
      default:      fill_nxt = fill_r;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_lft_edge
        assign left_w[g] = in_msg;
      end else begin : g_lft
        assign left_w[g] = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_rgt_edge
        assign right_w[g] = in_msg;
      end else begin : g_rgt
        assign right_w[g] = cell_data[g+1];
      end

      mpsd_cell #(
        .DEPTH (DEPTH),
        .IDX   (g),
        .FW    (FW)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .fill       (fill_r),
        .msg        (in_msg),
        .left_data  (left_w[g]),
        .right_data (right_w[g]),
        .data_o     (cell_data[g]),
        .tap_o      (cell_tap[g])
      );
    end
  endgenerate

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_code_r <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        empty_code_r <= cfg_wdata;
      end
      if (fire) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (fire) begin
      out_value_r     <= pop_hit ? tap_or : empty_code_r;
      out_valid_res_r <= pop_hit;
      out_count_r     <= COUNT_W'(fill_nxt);
      out_dropped_r   <= is_push && full;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_valid_res = out_valid_res_r;
  assign out_count     = out_count_r;
  assign out_dropped   = out_dropped_r;

endmodule
